>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked on every clock edge outside reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/sscp_pkg.sv
package sscp_pkg;

    // shadow stack geometry
    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

    // field widths
    localparam int COST_W   = 64;
    localparam int DEPTH_W  = 10;
    localparam int STATUS_W = 2;
    localparam int SCALE_W  = 32;
    localparam int GAP_W    = 32;

    localparam logic [SCALE_W-1:0] GAP_SCALE_RST = 32'd4519886;

    // park-miller generator
    localparam int                 RAND_W = 31;
    localparam logic [14:0]        PM_A   = 15'd16807;
    localparam logic [RAND_W-1:0]  PM_M   = 31'h7FFF_FFFF;

    // shared multiplier operand widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 21;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // log2 in q16, 31.0 minus log2 fits in MUL_B_W bits
    localparam int                  LOG_K_W = 5;
    localparam logic [MUL_B_W-1:0]  LOG_TOP = 21'(31 << 16);

    typedef enum logic [STATUS_W-1:0] {
        STAT_SAMPLE = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_FULL   = 2'd2
    } t_status;

    typedef enum logic {
        MODE_CALL = 1'b0,
        MODE_RET  = 1'b1
    } t_mode;

    typedef struct packed {
        logic               en;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [COST_W-1:0] wdata;
    } t_stk_req;

endpackage

>>> sv/sscp_mul.sv
module sscp_mul (
    input  logic                         i_clk,
    input  sscp_pkg::t_mul_req           i_req,
    output logic [sscp_pkg::PROD_W-1:0]  o_prod
);
    import sscp_pkg::*;

    logic [PROD_W-1:0] r_prod;

    // registered product, shared by the generator step and the gap scaling
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

>>> sv/sscp_stack.sv
module sscp_stack (
    input  logic                         i_clk,
    input  sscp_pkg::t_stk_req           i_req,
    output logic [sscp_pkg::COST_W-1:0]  o_rd_data
);
    import sscp_pkg::*;

    logic [COST_W-1:0] r_mem [STACK_DEPTH];
    logic [COST_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/shadow_stack_sampled_cost_profiler.sv
// shadow call stack profiler with geometric sampling
// input request: s_axis_tuser is the event kind (call or return), s_axis_tdata
// the running cost counter. a call pushes the cost onto the shadow stack, a
// return pops the top frame and, when the sample countdown has run out, sends
// one sample record (elapsed cost and frame depth) on the m_axis channel and
// reloads the countdown with a fresh geometric gap.
// a call on a full stack or a return on an empty stack sends a status record
// with zero elapsed cost and zero depth and changes nothing else.
// a call on a free stack needs no further state. a return reads the top frame in
// S_READ and, when due, runs S_RND_MUL, S_FOLD, S_LOG, S_GAP_MUL and S_CHECK
// (back to S_RND_MUL to redraw a gap one above the last one), then S_EMIT;
// status records go straight to S_EMIT. requests are taken only in S_IDLE.
// the sampled path uses the single shared multiplier for the generator step
// and the gap scaling, and the one-port stack with registered read data.
// results sit in an output register; the block goes on taking requests while
// a record waits, and only a new record waits for the register to drain.
// reset (i_rst_n low, synchronous) empties the stack, clears the countdown,
// reseeds the generator and loads the default gap scale; the stack memory
// itself is not cleared and needs no clearing pass.
// i_cfg_wr_en writes the gap scale (q16.16); the user must assert it only while idle, the block does not enforce this.
`include "assert_macros.svh"

module shadow_stack_sampled_cost_profiler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration: gap scale
    input  logic                            i_cfg_wr_en,
    input  logic [sscp_pkg::SCALE_W-1:0]    i_cfg_wr_data,
    // request channel
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [63:0]                     s_axis_tdata,  // [63:0] cost_now
    input  logic [0:0]                      s_axis_tuser,  // [0] mode
    // record channel
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [79:0]                     m_axis_tdata,  // [63:0] elapsed_cost,
                                                           // [73:64] depth, [79:74] zero
    output logic [1:0]                      m_axis_tuser   // [1:0] status
);
    import sscp_pkg::*;

    localparam int EXT_W = (COUNT_W > DEPTH_W) ? COUNT_W : DEPTH_W;

    // one-hot sequencer states
    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_READ    = 8'b0000_0010,
        S_RND_MUL = 8'b0000_0100,
        S_FOLD    = 8'b0000_1000,
        S_LOG     = 8'b0001_0000,
        S_GAP_MUL = 8'b0010_0000,
        S_CHECK   = 8'b0100_0000,
        S_EMIT    = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // profiler state
    logic [COUNT_W-1:0] r_frame_count;
    logic [GAP_W-1:0]   r_countdown;
    logic [GAP_W-1:0]   r_prev_gap;
    logic [RAND_W-1:0]  r_rand;
    logic [SCALE_W-1:0] r_gap_scale;

    // per-request working registers
    logic [COST_W-1:0]  r_cost;
    logic [COST_W-1:0]  r_elapsed;
    logic [DEPTH_W-1:0] r_depth;
    t_status            r_status;

    // scaled distance below 31.0 in q16
    logic [MUL_B_W-1:0] r_dist;

    // output register
    logic               r_out_valid;
    t_status            r_out_status;
    logic [COST_W-1:0]  r_out_elapsed;
    logic [DEPTH_W-1:0] r_out_depth;

    // datapath wires
    t_stk_req           w_stk_req;
    logic [COST_W-1:0]  w_stk_rd;
    t_mul_req           w_mul_req;
    logic [PROD_W-1:0]  w_prod;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic [COUNT_W-1:0] w_top;
    logic [EXT_W-1:0]   w_top_ext;
    logic               w_due;
    logic [GAP_W-1:0]   w_fold;
    logic [GAP_W-1:0]   w_gap;
    logic               w_redraw;
    logic [LOG_K_W-1:0] w_lead;
    logic [RAND_W-1:0]  w_norm;
    logic [MUL_B_W-1:0] w_log;
    logic               w_out_free;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_full     = (r_frame_count == COUNT_W'(STACK_DEPTH));
    assign w_empty    = (r_frame_count == '0);
    assign w_top      = r_frame_count - COUNT_W'(1);
    assign w_top_ext  = EXT_W'(w_top);
    // countdown run out: zero or negative
    assign w_due      = (r_countdown == '0) || r_countdown[GAP_W-1];
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);

    // stack port: push on call, read top on return
    always_comb begin
        w_stk_req       = '0;
        w_stk_req.wdata = s_axis_tdata;
        if (s_axis_tuser[0] == MODE_CALL) begin
            w_stk_req.addr  = r_frame_count[ADDR_W-1:0];
            w_stk_req.wr_en = w_accept && !w_full;
        end else begin
            w_stk_req.addr  = w_top[ADDR_W-1:0];
            w_stk_req.rd_en = w_accept && !w_empty;
        end
    end

    sscp_stack u_stack (
        .i_clk     (i_clk),
        .i_req     (w_stk_req),
        .o_rd_data (w_stk_rd)
    );

    // shared multiplier: generator step x * 16807, then distance * gap scale
    always_comb begin
        w_mul_req = '0;
        if (r_state == S_RND_MUL) begin
            w_mul_req.en = 1'b1;
            w_mul_req.a  = MUL_A_W'(r_rand);
            w_mul_req.b  = MUL_B_W'(PM_A);
        end else if (r_state == S_GAP_MUL) begin
            w_mul_req.en = 1'b1;
            w_mul_req.a  = r_gap_scale;
            w_mul_req.b  = r_dist;
        end
    end

    sscp_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod)
    );

    // reduction modulo 2^31-1: fold the high part onto the low part once
    assign w_fold = GAP_W'(w_prod[RAND_W-1:0]) + GAP_W'(w_prod[PROD_W-1:RAND_W]);

    // gap from the scaled product, plus one
    assign w_gap    = GAP_W'(w_prod[PROD_W-1:32]) + GAP_W'(1);
    assign w_redraw = (w_gap == r_prev_gap + GAP_W'(1));

    // leading-one index and normalized mantissa of the generator word
    always_comb begin
        w_lead = '0;
        for (int i = 0; i < RAND_W; i++) begin
            if (r_rand[i]) begin
                w_lead = LOG_K_W'(i);
            end
        end
    end

    assign w_norm = r_rand << (LOG_K_W'(RAND_W - 1) - w_lead);
    assign w_log  = {w_lead, w_norm[RAND_W-2:RAND_W-17]};

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser[0] == MODE_CALL) begin
                        if (w_full) begin
                            n_state = S_EMIT;
                        end
                    end else if (w_empty) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = w_due ? S_RND_MUL : S_IDLE;
            end
            S_RND_MUL: n_state = S_FOLD;
            S_FOLD:    n_state = S_LOG;
            S_LOG:     n_state = S_GAP_MUL;
            S_GAP_MUL: n_state = S_CHECK;
            S_CHECK: begin
                n_state = w_redraw ? S_RND_MUL : S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_frame_count <= '0;
            r_countdown   <= '0;
            r_prev_gap    <= '1;
            r_rand        <= RAND_W'(1);
            r_gap_scale   <= GAP_SCALE_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_gap_scale <= i_cfg_wr_data;
            end
            if (w_stk_req.wr_en) begin
                r_frame_count <= r_frame_count + COUNT_W'(1);
            end
            if (r_state == S_READ) begin
                r_frame_count <= w_top;
                if (!w_due) begin
                    r_countdown <= r_countdown - GAP_W'(1);
                end
            end
            if (r_state == S_FOLD) begin
                r_rand <= (w_fold >= GAP_W'(PM_M)) ? RAND_W'(w_fold - GAP_W'(PM_M))
                                                   : w_fold[RAND_W-1:0];
            end
            if (r_state == S_CHECK && !w_redraw) begin
                r_prev_gap  <= w_gap;
                r_countdown <= w_gap - GAP_W'(1);
            end
        end
    end

    // per-request payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cost    <= s_axis_tdata;
            r_elapsed <= '0;
            r_depth   <= '0;
            r_status  <= (s_axis_tuser[0] == MODE_CALL) ? STAT_FULL : STAT_EMPTY;
        end
        if (r_state == S_READ) begin
            r_elapsed <= r_cost - w_stk_rd;
            r_depth   <= w_top_ext[DEPTH_W-1:0];
            r_status  <= STAT_SAMPLE;
        end
        if (r_state == S_LOG) begin
            r_dist <= LOG_TOP - w_log;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free) begin
            r_out_status  <= r_status;
            r_out_elapsed <= r_elapsed;
            r_out_depth   <= r_depth;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {6'b0, r_out_depth, r_out_elapsed};

    // stack never holds more frames than it has entries
    `ASSERT_NOW(a_count_bound, 1'b1, r_frame_count <= COUNT_W'(STACK_DEPTH))
    // generator word stays inside 1 .. 2^31-2
    `ASSERT_NOW(a_rand_range, 1'b1, r_rand != '0 && r_rand != PM_M)
    // a serviced return pops exactly one frame
    `ASSERT_NEXT(a_pop_one, r_state == S_READ,
                 r_frame_count == $past(r_frame_count) - COUNT_W'(1))
    // an accepted gap is at least one, so the reloaded countdown is not negative
    `ASSERT_NEXT(a_gap_loaded, r_state == S_CHECK && !w_redraw,
                 !r_countdown[GAP_W-1] && r_prev_gap != '0)

endmodule
